// File: rtl/pfrs_pkg.sv
// Package for the palette fade block: sizes, microcode word layout and codes,
// configuration bundle, and the small colour and slew helper functions.
// Depends on nothing; every other file of the block but pfrs_if uses it.
`default_nettype none

package pfrs_pkg;

    // Block sizing.
    localparam int PALETTE_SIZE     = 8;
    localparam int STEPS_PER_COLOUR = 1000;

    localparam int LEVEL_W   = 8;
    localparam int SPEED_W   = 12;
    localparam int SCHED_W   = 2;
    localparam int PAL_W     = 48;
    localparam int COLOUR_W  = 12;
    localparam int LEVEL_MAX = 240;
    localparam int BRIGHT_FULL = 255;

    localparam int PAL_IDX_W = $clog2(PALETTE_SIZE);
    // The fraction briefly holds fraction plus speed before it is normalized.
    localparam int FRAC_W    = $clog2(STEPS_PER_COLOUR + (1 << SPEED_W));

    // Blend arithmetic widths.
    localparam int SUM_W     = $clog2(LEVEL_MAX * STEPS_PER_COLOUR + 1);
    localparam int NUM_W     = $clog2(LEVEL_MAX * STEPS_PER_COLOUR * BRIGHT_FULL + 1);
    localparam int BLEND_DIV = STEPS_PER_COLOUR * BRIGHT_FULL;

    // Division by BLEND_DIV is a multiply by a rounded-up reciprocal. With the
    // shift at NUM_W plus the divisor's bit length the quotient is exact for
    // every numerator of NUM_W bits.
    localparam int RECIP_SH = NUM_W + $clog2(BLEND_DIV);
    localparam longint unsigned RECIP_M =
        ((64'd1 << RECIP_SH) + 64'(BLEND_DIV) - 64'd1) / 64'(BLEND_DIV);
    localparam int RECIP_W  = $clog2(RECIP_M + 64'd1);
    localparam int PROD_W   = NUM_W + RECIP_W;

    // APB register map.
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_PALETTE_LOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PALETTE_HIGH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TRANS_STEPS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPEED        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCHEDULE     = 3'd5;

    // Microprogram.
    localparam int PC_W = 5;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ADD  = 2'd1;
    localparam logic [1:0] PH_NORM = 2'd2;

    localparam logic [1:0] DV_NONE = 2'd0;
    localparam logic [1:0] DV_INIT = 2'd1;
    localparam logic [1:0] DV_STEP = 2'd2;

    localparam logic [2:0] MU_NONE  = 3'd0;
    localparam logic [2:0] MU_A     = 3'd1;
    localparam logic [2:0] MU_B     = 3'd2;
    localparam logic [2:0] MU_ACC   = 3'd3;
    localparam logic [2:0] MU_BRT   = 3'd4;
    localparam logic [2:0] MU_RECIP = 3'd5;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [1:0] CD_NONE    = 2'd0;
    localparam logic [1:0] CD_FRAC_GE = 2'd1;

    localparam logic [PC_W-1:0] PC_NORM = PC_W'(1);

    typedef struct packed {
        logic [1:0]      phase_op;
        logic [1:0]      div_op;
        logic [2:0]      mul_op;
        logic [1:0]      chan;
        logic            save_en;
        logic [1:0]      save_ch;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
        logic            last;
    } ucw_t;

    localparam ucw_t UCW_NOP = '{
        phase_op: PH_NONE, div_op: DV_NONE, mul_op: MU_NONE, chan: CH_RED,
        save_en: 1'b0, save_ch: CH_RED, cond: CD_NONE, target: '0, last: 1'b0
    };

    typedef struct packed {
        logic exec;
        ucw_t word;
    } seq_ctrl_t;

    typedef struct packed {
        logic frac_ge;
    } dp_status_t;

    typedef struct packed {
        logic [PAL_W-1:0]   pal_lo;
        logic [PAL_W-1:0]   pal_hi;
        logic [LEVEL_W-1:0] brightness;
        logic [LEVEL_W-1:0] tsteps;
        logic [SPEED_W-1:0] speed;
        logic [SCHED_W-1:0] schedule;
    } cfg_t;

    // Palette entries wrap modulo the eight stored colours.
    function automatic logic [COLOUR_W-1:0] pal_colour(
        input logic [PAL_W-1:0]     lo,
        input logic [PAL_W-1:0]     hi,
        input logic [PAL_IDX_W-1:0] idx
    );
        logic [3:0]       wide;
        logic [PAL_W-1:0] word;
        wide = 4'(idx);
        word = wide[2] ? hi : lo;
        return word[COLOUR_W*wide[1:0] +: COLOUR_W];
    endfunction

    // A nibble becomes an 8-bit level of nibble times sixteen.
    function automatic logic [LEVEL_W-1:0] chan_level(
        input logic [COLOUR_W-1:0] colour,
        input logic [1:0]          ch
    );
        logic [LEVEL_W-1:0] lvl;
        case (ch)
            CH_RED:   lvl = {colour[11:8], 4'b0000};
            CH_GREEN: lvl = {colour[7:4], 4'b0000};
            CH_BLUE:  lvl = {colour[3:0], 4'b0000};
            default:  lvl = '0;
        endcase
        return lvl;
    endfunction

    function automatic logic [LEVEL_W-1:0] slew_step(
        input logic [LEVEL_W-1:0] tsteps,
        input logic [LEVEL_W-1:0] quo
    );
        logic [LEVEL_W-1:0] s;
        if (tsteps == '0)
            s = LEVEL_W'(BRIGHT_FULL);
        else if (quo == '0)
            s = LEVEL_W'(1);
        else
            s = quo;
        return s;
    endfunction

    function automatic logic [LEVEL_W-1:0] slew_level(
        input logic [LEVEL_W-1:0] t,
        input logic [LEVEL_W-1:0] c,
        input logic [LEVEL_W-1:0] s
    );
        logic [LEVEL_W:0]   up;
        logic [LEVEL_W:0]   t_plus;
        logic [LEVEL_W-1:0] r;
        up     = {1'b0, c} + {1'b0, s};
        t_plus = {1'b0, t} + {1'b0, s};
        if (t > c)
            r = (up > {1'b0, t}) ? t : up[LEVEL_W-1:0];
        else
            r = ({1'b0, c} >= t_plus) ? LEVEL_W'(c - s) : t;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pfrs_if.sv
// Handshake interfaces of the palette fade block: the tick channel and the
// level channel. Depends on nothing.
`default_nettype none

interface pfrs_tick_if;
    logic valid;
    logic ready;
    logic is_night;

    modport source (output valid, output is_night, input ready);
    modport sink (input valid, input is_night, output ready);
endinterface

interface pfrs_level_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink (input valid, input red_level, input green_level,
                  input blue_level, output ready);
endinterface

`default_nettype wire

// File: rtl/pfrs_ucode_rom.sv
// Microcode table of the palette fade block: one control word per step.
// Depends on pfrs_pkg.
`default_nettype none

module pfrs_ucode_rom (
    input  wire logic [pfrs_pkg::PC_W-1:0] pc,
    output pfrs_pkg::ucw_t                  word
);

    always_comb
    begin
        word = pfrs_pkg::UCW_NOP;
        case (pc)
            pfrs_pkg::PC_W'(0):
            begin
                word.phase_op = pfrs_pkg::PH_ADD;
                word.div_op   = pfrs_pkg::DV_INIT;
            end
            pfrs_pkg::PC_W'(1):
            begin
                // Subtract one colour span per pass until the fraction is in range.
                word.phase_op = pfrs_pkg::PH_NORM;
                word.cond     = pfrs_pkg::CD_FRAC_GE;
                word.target   = pfrs_pkg::PC_NORM;
            end
            pfrs_pkg::PC_W'(2):
            begin
                word.mul_op = pfrs_pkg::MU_A;
                word.chan   = pfrs_pkg::CH_RED;
                word.div_op = pfrs_pkg::DV_STEP;
            end
            pfrs_pkg::PC_W'(3):
            begin
                word.mul_op = pfrs_pkg::MU_B;
                word.chan   = pfrs_pkg::CH_RED;
                word.div_op = pfrs_pkg::DV_STEP;
            end
            pfrs_pkg::PC_W'(4):
            begin
                word.mul_op = pfrs_pkg::MU_ACC;
                word.div_op = pfrs_pkg::DV_STEP;
            end
            pfrs_pkg::PC_W'(5):
            begin
                word.mul_op = pfrs_pkg::MU_BRT;
                word.div_op = pfrs_pkg::DV_STEP;
            end
            pfrs_pkg::PC_W'(6):
            begin
                word.mul_op = pfrs_pkg::MU_RECIP;
                word.div_op = pfrs_pkg::DV_STEP;
            end
            pfrs_pkg::PC_W'(7):
            begin
                word.mul_op  = pfrs_pkg::MU_A;
                word.chan    = pfrs_pkg::CH_GREEN;
                word.save_en = 1'b1;
                word.save_ch = pfrs_pkg::CH_RED;
                word.div_op  = pfrs_pkg::DV_STEP;
            end
            pfrs_pkg::PC_W'(8):
            begin
                word.mul_op = pfrs_pkg::MU_B;
                word.chan   = pfrs_pkg::CH_GREEN;
                word.div_op = pfrs_pkg::DV_STEP;
            end
            pfrs_pkg::PC_W'(9):
            begin
                word.mul_op = pfrs_pkg::MU_ACC;
                word.div_op = pfrs_pkg::DV_STEP;
            end
            pfrs_pkg::PC_W'(10):
            begin
                word.mul_op = pfrs_pkg::MU_BRT;
            end
            pfrs_pkg::PC_W'(11):
            begin
                word.mul_op = pfrs_pkg::MU_RECIP;
            end
            pfrs_pkg::PC_W'(12):
            begin
                word.mul_op  = pfrs_pkg::MU_A;
                word.chan    = pfrs_pkg::CH_BLUE;
                word.save_en = 1'b1;
                word.save_ch = pfrs_pkg::CH_GREEN;
            end
            pfrs_pkg::PC_W'(13):
            begin
                word.mul_op = pfrs_pkg::MU_B;
                word.chan   = pfrs_pkg::CH_BLUE;
            end
            pfrs_pkg::PC_W'(14):
            begin
                word.mul_op = pfrs_pkg::MU_ACC;
            end
            pfrs_pkg::PC_W'(15):
            begin
                word.mul_op = pfrs_pkg::MU_BRT;
            end
            pfrs_pkg::PC_W'(16):
            begin
                word.mul_op = pfrs_pkg::MU_RECIP;
            end
            pfrs_pkg::PC_W'(17):
            begin
                word.save_en = 1'b1;
                word.save_ch = pfrs_pkg::CH_BLUE;
            end
            pfrs_pkg::PC_W'(18):
            begin
                word.last = 1'b1;
            end
            default:
            begin
                // Addresses past the program end the item safely.
                word.last = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pfrs_sequencer.sv
// Step counter and jump logic of the palette fade block; reads the microcode
// table. Depends on pfrs_pkg and pfrs_ucode_rom.
`default_nettype none

module pfrs_sequencer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                out_free,
    input  wire pfrs_pkg::dp_status_t status,
    output logic                     busy,
    output pfrs_pkg::seq_ctrl_t      ctrl
);

    logic [pfrs_pkg::PC_W-1:0] pc_reg;
    logic [pfrs_pkg::PC_W-1:0] pc_next;
    logic                      busy_reg;
    logic                      busy_next;
    pfrs_pkg::ucw_t            word;
    logic                      taken;

    pfrs_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    always_comb
    begin
        case (word.cond)
            pfrs_pkg::CD_FRAC_GE: taken = status.frac_ge;
            default:              taken = 1'b0;
        endcase
    end

    // The final step waits while the level output still holds a result.
    assign ctrl.word = word;
    assign ctrl.exec = busy_reg && !(word.last && !out_free);
    assign busy      = busy_reg;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = '0;
            busy_next = 1'b1;
        end
        else if (ctrl.exec)
        begin
            if (word.last)
            begin
                pc_next   = '0;
                busy_next = 1'b0;
            end
            else if (taken)
                pc_next = word.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pfrs_datapath.sv
// Datapath of the palette fade block: phase, shared multiplier, reciprocal
// divide, bit-serial slew divider and the three level registers.
// Depends on pfrs_pkg.
`default_nettype none

module pfrs_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                is_night,
    input  wire pfrs_pkg::cfg_t      cfg,
    input  wire pfrs_pkg::seq_ctrl_t ctrl,
    output pfrs_pkg::dp_status_t     status,
    output logic [pfrs_pkg::LEVEL_W-1:0] red_level,
    output logic [pfrs_pkg::LEVEL_W-1:0] green_level,
    output logic [pfrs_pkg::LEVEL_W-1:0] blue_level
);

    localparam int LW = pfrs_pkg::LEVEL_W;

    logic [pfrs_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic [pfrs_pkg::PAL_IDX_W-1:0] idx_reg, idx_next;
    logic                           night_reg;
    logic [LW-1:0]                  rem_reg, rem_next;
    logic [LW-1:0]                  quo_reg, quo_next;
    logic [pfrs_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [pfrs_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [2:0][LW-1:0]             tgt_reg, tgt_next;
    logic [2:0][LW-1:0]             cur_reg, cur_next;

    logic [pfrs_pkg::PAL_IDX_W-1:0] idx_succ;
    logic [pfrs_pkg::COLOUR_W-1:0]  colour_a, colour_b;
    logic [LW-1:0]                  lvl_a, lvl_b;
    logic                           enabled;
    logic [LW-1:0]                  bright_eff;
    logic [pfrs_pkg::FRAC_W-1:0]    frac_inv;
    logic [pfrs_pkg::NUM_W-1:0]     mul_x;
    logic [pfrs_pkg::RECIP_W-1:0]   mul_y;
    logic [pfrs_pkg::PROD_W-1:0]    prod_full;
    logic [LW:0]                    div_shift;
    logic [LW-1:0]                  step;
    logic [LW-1:0]                  quot_out;

    assign idx_succ = (idx_reg == pfrs_pkg::PAL_IDX_W'(pfrs_pkg::PALETTE_SIZE - 1))
                      ? '0 : idx_reg + 1'b1;
    assign colour_a = pfrs_pkg::pal_colour(cfg.pal_lo, cfg.pal_hi, idx_reg);
    assign colour_b = pfrs_pkg::pal_colour(cfg.pal_lo, cfg.pal_hi, idx_succ);
    assign lvl_a    = pfrs_pkg::chan_level(colour_a, ctrl.word.chan);
    assign lvl_b    = pfrs_pkg::chan_level(colour_b, ctrl.word.chan);

    assign enabled    = night_reg ? cfg.schedule[1] : cfg.schedule[0];
    assign bright_eff = enabled ? cfg.brightness : '0;
    assign frac_inv   = pfrs_pkg::FRAC_W'(pfrs_pkg::STEPS_PER_COLOUR) - frac_reg;

    assign status.frac_ge = frac_reg >= pfrs_pkg::FRAC_W'(pfrs_pkg::STEPS_PER_COLOUR);

    // One multiplier serves every product of the blend.
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (ctrl.word.mul_op)
            pfrs_pkg::MU_A:
            begin
                mul_x = pfrs_pkg::NUM_W'(lvl_a);
                mul_y = pfrs_pkg::RECIP_W'(frac_inv);
            end
            pfrs_pkg::MU_B:
            begin
                mul_x = pfrs_pkg::NUM_W'(lvl_b);
                mul_y = pfrs_pkg::RECIP_W'(frac_reg);
            end
            pfrs_pkg::MU_BRT:
            begin
                mul_x = pfrs_pkg::NUM_W'(sum_reg);
                mul_y = pfrs_pkg::RECIP_W'(bright_eff);
            end
            pfrs_pkg::MU_RECIP:
            begin
                mul_x = prod_reg[pfrs_pkg::NUM_W-1:0];
                mul_y = pfrs_pkg::RECIP_W'(pfrs_pkg::RECIP_M);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod_full = mul_x * mul_y;
    assign quot_out  = prod_reg[pfrs_pkg::RECIP_SH +: LW];
    assign div_shift = {rem_reg, quo_reg[LW-1]};
    assign step      = pfrs_pkg::slew_step(cfg.tsteps, quo_reg);

    always_comb
    begin
        frac_next = frac_reg;
        idx_next  = idx_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        sum_next  = sum_reg;
        prod_next = prod_reg;
        tgt_next  = tgt_reg;
        cur_next  = cur_reg;

        if (ctrl.exec)
        begin
            case (ctrl.word.phase_op)
                pfrs_pkg::PH_ADD:
                    frac_next = frac_reg + pfrs_pkg::FRAC_W'(cfg.speed);
                pfrs_pkg::PH_NORM:
                begin
                    if (status.frac_ge)
                    begin
                        frac_next = frac_reg
                                    - pfrs_pkg::FRAC_W'(pfrs_pkg::STEPS_PER_COLOUR);
                        idx_next  = idx_succ;
                    end
                end
                default:
                    frac_next = frac_reg;
            endcase

            // Restoring division of brightness by the transition step count.
            case (ctrl.word.div_op)
                pfrs_pkg::DV_INIT:
                begin
                    rem_next = '0;
                    quo_next = cfg.brightness;
                end
                pfrs_pkg::DV_STEP:
                begin
                    if (div_shift >= {1'b0, cfg.tsteps})
                    begin
                        rem_next = LW'(div_shift - {1'b0, cfg.tsteps});
                        quo_next = {quo_reg[LW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = div_shift[LW-1:0];
                        quo_next = {quo_reg[LW-2:0], 1'b0};
                    end
                end
                default:
                    rem_next = rem_reg;
            endcase

            case (ctrl.word.mul_op)
                pfrs_pkg::MU_A, pfrs_pkg::MU_BRT, pfrs_pkg::MU_RECIP:
                    prod_next = prod_full;
                pfrs_pkg::MU_B:
                begin
                    prod_next = prod_full;
                    sum_next  = prod_reg[pfrs_pkg::SUM_W-1:0];
                end
                pfrs_pkg::MU_ACC:
                    sum_next = sum_reg + prod_reg[pfrs_pkg::SUM_W-1:0];
                default:
                    prod_next = prod_reg;
            endcase

            if (ctrl.word.save_en)
            begin
                case (ctrl.word.save_ch)
                    pfrs_pkg::CH_RED:   tgt_next[0] = quot_out;
                    pfrs_pkg::CH_GREEN: tgt_next[1] = quot_out;
                    pfrs_pkg::CH_BLUE:  tgt_next[2] = quot_out;
                    default:            tgt_next    = tgt_reg;
                endcase
            end

            if (ctrl.word.last)
            begin
                cur_next[0] = pfrs_pkg::slew_level(tgt_reg[0], cur_reg[0], step);
                cur_next[1] = pfrs_pkg::slew_level(tgt_reg[1], cur_reg[1], step);
                cur_next[2] = pfrs_pkg::slew_level(tgt_reg[2], cur_reg[2], step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= '0;
            idx_reg  <= '0;
            cur_reg  <= '0;
        end
        else
        begin
            frac_reg <= frac_next;
            idx_reg  <= idx_next;
            cur_reg  <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            night_reg <= is_night;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        tgt_reg  <= tgt_next;
    end

    assign red_level   = cur_reg[0];
    assign green_level = cur_reg[1];
    assign blue_level  = cur_reg[2];

endmodule

`default_nettype wire

// File: rtl/palette_fade_rgb_slew.sv
// Palette fade with slew limit: one tick in, one RGB level triple out.
// Each tick runs the 19-step microprogram on one shared multiplier, with one more pass
// of the normalize step for each colour span the phase crosses (0 to 5 with a 12-bit
// speed); no new tick is taken until the program for the last one has finished.
// Reset (rst_n, asynchronous, active low) clears the configuration registers, phase
// and levels to zero; tick ready is high as soon as reset is released.
`default_nettype none

module palette_fade_rgb_slew (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pfrs_tick_if.sink                          tick,
    pfrs_level_if.source                       level,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pfrs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pfrs_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [pfrs_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);

    // Configuration registers. Each register sits at eight times its index,
    // so the upper address bits select it and the byte offset is ignored.
    logic [pfrs_pkg::PAL_W-1:0]   pal_lo_reg;
    logic [pfrs_pkg::PAL_W-1:0]   pal_hi_reg;
    logic [pfrs_pkg::LEVEL_W-1:0] brightness_reg;
    logic [pfrs_pkg::LEVEL_W-1:0] tsteps_reg;
    logic [pfrs_pkg::SPEED_W-1:0] speed_reg;
    logic [pfrs_pkg::SCHED_W-1:0] schedule_reg;

    logic [pfrs_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_wr;
    pfrs_pkg::cfg_t                 cfg;

    // Sequencer and datapath links.
    pfrs_pkg::seq_ctrl_t  ctrl;
    pfrs_pkg::dp_status_t status;
    logic                 busy;
    logic                 start;
    logic                 out_free;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    assign pready  = 1'b1;
    assign reg_idx = paddr[pfrs_pkg::APB_ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_lo_reg     <= '0;
            pal_hi_reg     <= '0;
            brightness_reg <= '0;
            tsteps_reg     <= '0;
            speed_reg      <= '0;
            schedule_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                pfrs_pkg::REG_PALETTE_LOW:  pal_lo_reg     <= pwdata[pfrs_pkg::PAL_W-1:0];
                pfrs_pkg::REG_PALETTE_HIGH: pal_hi_reg     <= pwdata[pfrs_pkg::PAL_W-1:0];
                pfrs_pkg::REG_BRIGHTNESS:   brightness_reg <= pwdata[pfrs_pkg::LEVEL_W-1:0];
                pfrs_pkg::REG_TRANS_STEPS:  tsteps_reg     <= pwdata[pfrs_pkg::LEVEL_W-1:0];
                pfrs_pkg::REG_SPEED:        speed_reg      <= pwdata[pfrs_pkg::SPEED_W-1:0];
                pfrs_pkg::REG_SCHEDULE:     schedule_reg   <= pwdata[pfrs_pkg::SCHED_W-1:0];
                default:                    schedule_reg   <= schedule_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pfrs_pkg::REG_PALETTE_LOW:  prdata = pfrs_pkg::APB_DATA_W'(pal_lo_reg);
            pfrs_pkg::REG_PALETTE_HIGH: prdata = pfrs_pkg::APB_DATA_W'(pal_hi_reg);
            pfrs_pkg::REG_BRIGHTNESS:   prdata = pfrs_pkg::APB_DATA_W'(brightness_reg);
            pfrs_pkg::REG_TRANS_STEPS:  prdata = pfrs_pkg::APB_DATA_W'(tsteps_reg);
            pfrs_pkg::REG_SPEED:        prdata = pfrs_pkg::APB_DATA_W'(speed_reg);
            pfrs_pkg::REG_SCHEDULE:     prdata = pfrs_pkg::APB_DATA_W'(schedule_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.pal_lo     = pal_lo_reg;
    assign cfg.pal_hi     = pal_hi_reg;
    assign cfg.brightness = brightness_reg;
    assign cfg.tsteps     = tsteps_reg;
    assign cfg.speed      = speed_reg;
    assign cfg.schedule   = schedule_reg;

    // A tick transaction is taken whenever no program is running. The level
    // registers in the datapath double as the output register: they change
    // only on the final step, and that step waits until the level channel
    // has taken the previous result, so a new tick can be accepted while a
    // result is still pending.
    assign tick.ready = !busy;
    assign start      = tick.valid && tick.ready;
    assign out_free   = !out_valid_reg || level.ready;

    pfrs_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .status   (status),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    pfrs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .is_night    (tick.is_night),
        .cfg         (cfg),
        .ctrl        (ctrl),
        .status      (status),
        .red_level   (level.red_level),
        .green_level (level.green_level),
        .blue_level  (level.blue_level)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.exec && ctrl.word.last)
            out_valid_next = 1'b1;
        else if (level.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign level.valid = out_valid_reg;

    // The final step never overwrites a result the sink has not taken.
    a_final_step_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && ctrl.word.last) |-> (!level.valid || level.ready))
        else $error("final step ran while a level result was pending");

    // Microcode only runs while the tick channel is closed.
    a_exec_blocks_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |-> !tick.ready)
        else $error("microcode step ran while ticks were accepted");

    // A new result appears only right after the final step.
    a_valid_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(level.valid) |-> $past(ctrl.exec && ctrl.word.last))
        else $error("level result appeared without a final step");

    // Blending starts only with a normalized phase fraction.
    a_frac_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && ctrl.word.mul_op == pfrs_pkg::MU_A) |-> !status.frac_ge)
        else $error("blend started with fraction out of range");

endmodule

`default_nettype wire
